FILE: rtl/mexp_pkg.sv
// Shared types for the modular exponentiation block: controller states,
// command and status bundles between controller and datapath.
// No dependencies.
package mexp_pkg;

   // base field width is fixed by the item format
   localparam int BASE_WIDTH = 63;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_BASE_GO,
      ST_BASE_WAIT,
      ST_CHECK,
      ST_ACC_MUL,
      ST_ACC_GO,
      ST_ACC_WAIT,
      ST_SQ_MUL,
      ST_SQ_GO,
      ST_SQ_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic {
      MUL_ACC,   // acc * b
      MUL_SQR    // b * b
   } mul_sel_type;

   typedef enum logic {
      RED_BASE,  // reduce the raw input base
      RED_PROD   // reduce the registered product
   } red_sel_type;

   typedef struct packed {
      logic        load_ops;
      logic        red_start;
      red_sel_type red_sel;
      logic        mul_start;
      mul_sel_type mul_sel;
      logic        acc_we;
      logic        b_we;
      logic        exp_shift;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic red_done;
      logic mod_zero;
      logic exp_zero;
      logic exp_lsb;
      logic exp_rest_zero;
   } status_type;

endpackage

FILE: rtl/modular_exponentiation.sv
// Top level of the modular exponentiation block: controller plus datapath.
// Depends on mexp_pkg, mexp_ctrl, mexp_datapath (and mexp_reduce below it).
//
// Computes req_base ** req_exponent mod req_modulus by right-to-left
// square-and-multiply. An item is taken when start is high and busy is low;
// busy stays high until the result is produced, and the result appears on
// rsp_power_result for exactly one cycle with rsp_valid high. The receiver
// cannot stall, so it must capture the result in that cycle. A zero modulus
// returns 0; a zero exponent returns 1 (also for a modulus of 1). Every
// multiply goes through one registered MOD_WIDTH x MOD_WIDTH multiplier
// followed by a shared bit-serial remainder unit that retires one dividend
// bit per cycle; that unit sets the rate. With D = max(63, 2*MOD_WIDTH)
// dividend bits, each multiply-and-reduce step and the base reduction
// shift all D bits through that unit. Each exponent bit up to the highest
// set bit costs a pass through the check state plus a squaring step, each
// set bit adds a multiply step, and the squaring after the top bit is
// skipped. The zero-modulus and zero-exponent cases go from the decide
// state straight to the finish state. One item is in flight at a time.
module modular_exponentiation #(
   parameter int MOD_WIDTH = 32,
   parameter int EXP_WIDTH = 63
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [mexp_pkg::BASE_WIDTH-1:0] req_base,
   input  logic [EXP_WIDTH-1:0]            req_exponent,
   input  logic [MOD_WIDTH-1:0]            req_modulus,
   output logic                            rsp_valid,
   output logic [MOD_WIDTH-1:0]            rsp_power_result
);

   mexp_pkg::cmd_type    cmd;
   mexp_pkg::status_type status;

   // sequencing: decide special cases, reduce base, then per exponent bit
   // an optional acc*b step and, below the top set bit, a b*b step
   mexp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   mexp_datapath #(
      .MOD_WIDTH (MOD_WIDTH),
      .EXP_WIDTH (EXP_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .req_modulus      (req_modulus),
      .rsp_valid        (rsp_valid),
      .rsp_power_result (rsp_power_result)
   );

endmodule

FILE: rtl/mexp_reduce.sv
// Bit-serial remainder unit: operand mod modulus, one dividend bit per cycle.
// Depends on nothing; instantiated by mexp_datapath.
module mexp_reduce #(
   parameter int MOD_WIDTH = 32,
   parameter int DIV_WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_WIDTH-1:0] operand,
   input  logic [MOD_WIDTH-1:0] modulus,
   output logic [MOD_WIDTH-1:0] remainder,
   output logic                 done
);

   localparam int CNT_WIDTH = $clog2(DIV_WIDTH + 1);

   logic [DIV_WIDTH-1:0] div_ff;
   logic [MOD_WIDTH-1:0] rem_ff, rem_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic                 run;
   logic [MOD_WIDTH:0]   trial;

   assign run = (cnt_ff != '0);

   // shift in next dividend bit, subtract modulus when it fits
   always_comb begin
      trial = {rem_ff, div_ff[DIV_WIDTH-1]};
      if (trial >= {1'b0, modulus}) begin
         trial = trial - {1'b0, modulus};
      end
      rem_in = trial[MOD_WIDTH-1:0];
   end

   always_comb begin
      if (start) begin
         cnt_in = CNT_WIDTH'(DIV_WIDTH);
      end else if (run) begin
         cnt_in = cnt_ff - CNT_WIDTH'(1);
      end else begin
         cnt_in = cnt_ff;
      end
      done_in = run && (cnt_ff == CNT_WIDTH'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         div_ff <= operand;
         rem_ff <= '0;
      end else if (run) begin
         div_ff <= div_ff << 1;
         rem_ff <= rem_in;
      end
   end

   assign remainder = rem_ff;
   assign done      = done_ff;

endmodule

FILE: rtl/mexp_datapath.sv
// Datapath: operand registers, one multiplier, the serial reducer and the
// result register. Depends on mexp_pkg and mexp_reduce.
module mexp_datapath #(
   parameter int MOD_WIDTH = 32,
   parameter int EXP_WIDTH = 63
) (
   input  logic                             clock,
   input  logic                             reset,
   input  mexp_pkg::cmd_type                cmd,
   output mexp_pkg::status_type             status,
   input  logic [mexp_pkg::BASE_WIDTH-1:0]  req_base,
   input  logic [EXP_WIDTH-1:0]             req_exponent,
   input  logic [MOD_WIDTH-1:0]             req_modulus,
   output logic                             rsp_valid,
   output logic [MOD_WIDTH-1:0]             rsp_power_result
);

   localparam int PROD_WIDTH = 2 * MOD_WIDTH;
   localparam int DIV_WIDTH  = (mexp_pkg::BASE_WIDTH > PROD_WIDTH) ?
                               mexp_pkg::BASE_WIDTH : PROD_WIDTH;

   logic [mexp_pkg::BASE_WIDTH-1:0] base_ff;
   logic [EXP_WIDTH-1:0]            exp_ff;
   logic [MOD_WIDTH-1:0]            mod_ff;
   logic [MOD_WIDTH-1:0]            acc_ff;
   logic [MOD_WIDTH-1:0]            b_ff;
   logic [PROD_WIDTH-1:0]           prod_ff;
   logic [MOD_WIDTH-1:0]            result_ff;
   logic                            valid_ff;

   logic [MOD_WIDTH-1:0]            mul_a;
   logic [DIV_WIDTH-1:0]            red_operand;
   logic [MOD_WIDTH-1:0]            red_rem;
   logic                            red_done;

   assign mul_a = (cmd.mul_sel == mexp_pkg::MUL_ACC) ? acc_ff : b_ff;
   assign red_operand = (cmd.red_sel == mexp_pkg::RED_BASE) ?
                        DIV_WIDTH'(base_ff) : DIV_WIDTH'(prod_ff);

   mexp_reduce #(
      .MOD_WIDTH (MOD_WIDTH),
      .DIV_WIDTH (DIV_WIDTH)
   ) u_reduce (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.red_start),
      .operand   (red_operand),
      .modulus   (mod_ff),
      .remainder (red_rem),
      .done      (red_done)
   );

   always_ff @(posedge clock) begin
      if (cmd.load_ops) begin
         base_ff <= req_base;
         mod_ff  <= req_modulus;
      end
      if (cmd.load_ops) begin
         exp_ff <= req_exponent;
      end else if (cmd.exp_shift) begin
         exp_ff <= exp_ff >> 1;
      end
      if (cmd.load_ops) begin
         acc_ff <= MOD_WIDTH'(1);
      end else if (cmd.acc_we) begin
         acc_ff <= red_rem;
      end
      if (cmd.b_we) begin
         b_ff <= red_rem;
      end
      if (cmd.mul_start) begin
         prod_ff <= PROD_WIDTH'(mul_a) * PROD_WIDTH'(b_ff);
      end
      // acc is still 1 on the exponent-zero path
      if (cmd.finish) begin
         result_ff <= (mod_ff == '0) ? '0 : acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish;
      end
   end

   always_comb begin
      status.red_done      = red_done;
      status.mod_zero      = (mod_ff == '0);
      status.exp_zero      = (exp_ff == '0);
      status.exp_lsb       = exp_ff[0];
      status.exp_rest_zero = ((exp_ff >> 1) == '0);
   end

   assign rsp_valid        = valid_ff;
   assign rsp_power_result = result_ff;

endmodule

FILE: rtl/mexp_ctrl.sv
// Controller FSM sequencing base reduction and square-and-multiply steps.
// Depends on mexp_pkg.
module mexp_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  mexp_pkg::status_type status,
   output mexp_pkg::cmd_type    cmd,
   output logic                 busy
);

   mexp_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mexp_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mexp_pkg::ST_IDLE: begin
            if (start) state_in = mexp_pkg::ST_DECIDE;
         end
         mexp_pkg::ST_DECIDE: begin
            if (status.mod_zero || status.exp_zero) begin
               state_in = mexp_pkg::ST_FINISH;
            end else begin
               state_in = mexp_pkg::ST_BASE_GO;
            end
         end
         mexp_pkg::ST_BASE_GO:   state_in = mexp_pkg::ST_BASE_WAIT;
         mexp_pkg::ST_BASE_WAIT: begin
            if (status.red_done) state_in = mexp_pkg::ST_CHECK;
         end
         mexp_pkg::ST_CHECK: begin
            if (status.exp_lsb) begin
               state_in = mexp_pkg::ST_ACC_MUL;
            end else begin
               state_in = mexp_pkg::ST_SQ_MUL;
            end
         end
         mexp_pkg::ST_ACC_MUL: state_in = mexp_pkg::ST_ACC_GO;
         mexp_pkg::ST_ACC_GO:  state_in = mexp_pkg::ST_ACC_WAIT;
         mexp_pkg::ST_ACC_WAIT: begin
            if (status.red_done) begin
               state_in = status.exp_rest_zero ? mexp_pkg::ST_FINISH
                                               : mexp_pkg::ST_SQ_MUL;
            end
         end
         mexp_pkg::ST_SQ_MUL: state_in = mexp_pkg::ST_SQ_GO;
         mexp_pkg::ST_SQ_GO:  state_in = mexp_pkg::ST_SQ_WAIT;
         mexp_pkg::ST_SQ_WAIT: begin
            if (status.red_done) begin
               state_in = status.exp_rest_zero ? mexp_pkg::ST_FINISH
                                               : mexp_pkg::ST_CHECK;
            end
         end
         mexp_pkg::ST_FINISH: state_in = mexp_pkg::ST_IDLE;
         default:             state_in = mexp_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.red_sel = mexp_pkg::RED_PROD;
      cmd.mul_sel = mexp_pkg::MUL_SQR;
      busy      = (state_ff != mexp_pkg::ST_IDLE);
      unique case (state_ff)
         mexp_pkg::ST_IDLE:      cmd.load_ops = start;
         mexp_pkg::ST_BASE_GO: begin
            cmd.red_start = 1'b1;
            cmd.red_sel   = mexp_pkg::RED_BASE;
         end
         mexp_pkg::ST_BASE_WAIT: cmd.b_we = status.red_done;
         mexp_pkg::ST_ACC_MUL: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = mexp_pkg::MUL_ACC;
         end
         mexp_pkg::ST_ACC_GO:    cmd.red_start = 1'b1;
         mexp_pkg::ST_ACC_WAIT:  cmd.acc_we = status.red_done;
         mexp_pkg::ST_SQ_MUL:    cmd.mul_start = 1'b1;
         mexp_pkg::ST_SQ_GO:     cmd.red_start = 1'b1;
         mexp_pkg::ST_SQ_WAIT: begin
            cmd.b_we      = status.red_done;
            cmd.exp_shift = status.red_done;
         end
         mexp_pkg::ST_FINISH:    cmd.finish = 1'b1;
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/mexp_checker.sv
// Port-level checks for modular_exponentiation, attached by bind.
// Depends on the top level's port names only.
module mexp_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid
);

   // an accepted item makes the block busy
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // result strobe lasts a single cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // result only shows once the block is free again
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // every completed item delivers its result
   assert property (@(posedge clock) disable iff (reset)
      $fell(busy) && !$past(reset) |-> rsp_valid)
      else $error("busy dropped without a result");

endmodule

bind modular_exponentiation mexp_checker u_mexp_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
